>>> rtl/sacc_pkg.sv
package sacc_pkg;

  localparam int WAYS_DEF        = 4;
  localparam int SETS_LOG2_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int ADDR_W   = 32;
  localparam int TAG_W    = 32;
  localparam int WAY_OUT_W = 2;
  localparam int OUT_W    = 40;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_REPL_POLICY = 2'd0;
  localparam logic [1:0] REG_WB_MODE     = 2'd1;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd2;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd3;

  localparam logic       RST_REPL_POLICY = 1'b0;
  localparam logic       RST_WB_MODE     = 1'b1;
  localparam logic [3:0] RST_OFFSET_BITS = 4'd5;
  localparam logic [3:0] RST_INDEX_BITS  = 4'd8;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;
  localparam logic OP_WRITE   = 1'b1;

  typedef struct packed {
    logic       repl_policy;
    logic       write_back_mode;
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/sacc_ram.sv
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/sacc_ctrl.sv
module sacc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  sacc_pkg::stat_t stat,
  output sacc_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  logic state;
  logic state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // The set row read is held until the result register has room.
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/sacc_dp.sv
module sacc_dp #(
  parameter int WAYS        = sacc_pkg::WAYS_DEF,
  parameter int SETS_LOG2   = sacc_pkg::SETS_LOG2_DEF,
  parameter int COUNT_WIDTH = sacc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sacc_pkg::cfg_t              cfg,
  input  sacc_pkg::cmd_t              cmd,
  output sacc_pkg::stat_t             stat,
  input  logic [sacc_pkg::ADDR_W-1:0] s_tdata,
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sacc_pkg::OUT_W-1:0]  m_tdata
);

  localparam int NSETS = 1 << SETS_LOG2;
  localparam int SET_W = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TW    = sacc_pkg::TAG_W;
  localparam int WF    = TW + 2 + WAY_W + COUNT_WIDTH;
  localparam int ROW_W = WAYS * WF + COUNT_WIDTH;
  localparam int P_VAL = TW;
  localparam int P_DRT = TW + 1;
  localparam int P_RNK = TW + 2;
  localparam int P_CNT = TW + 2 + WAY_W;
  localparam logic [3:0] IDX_MAX = 4'(SETS_LOG2);

  logic [3:0]       idx_eff;
  logic [4:0]       tag_sh;
  logic [SET_W-1:0] set_in;
  logic [31:0]      set_wide;

  logic [SET_W-1:0] set_q;
  logic [TW-1:0]    tag_q;
  logic             op_q;

  logic [NSETS-1:0] row_init;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_wr;
  logic [ROW_W-1:0] row_rst;

  logic [TW-1:0]          tag_r   [WAYS];
  logic                   val_r   [WAYS];
  logic                   drt_r   [WAYS];
  logic [WAY_W-1:0]       rnk_r   [WAYS];
  logic [COUNT_WIDTH-1:0] cnt_r   [WAYS];
  logic [COUNT_WIDTH-1:0] age_r;

  logic [TW-1:0]          tag_w   [WAYS];
  logic                   val_w   [WAYS];
  logic                   drt_w   [WAYS];
  logic [WAY_W-1:0]       rnk_w   [WAYS];
  logic [COUNT_WIDTH-1:0] cnt_w   [WAYS];
  logic [COUNT_WIDTH-1:0] age_w;

  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             inv_found;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] lfu_way;
  logic [WAY_W-1:0] sel_way;
  logic             do_touch;
  logic [WAY_W-1:0] touch_rank;

  logic        res_hit;
  logic        res_alloc;
  logic        res_evict;
  logic [31:0] res_eaddr;

  always_comb begin
    idx_eff  = (cfg.index_bits > IDX_MAX) ? IDX_MAX : cfg.index_bits;
    tag_sh   = 5'(cfg.offset_bits) + 5'(idx_eff);
    set_wide = (s_tdata >> cfg.offset_bits) & ((32'h1 << idx_eff) - 32'h1);
    set_in   = SET_W'(set_wide);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q <= set_in;
      tag_q <= s_tdata >> tag_sh;
      op_q  <= s_tuser;
    end
  end

  // A set row that was never written reads as its reset contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (cmd.commit) begin
      row_init[set_q] <= 1'b1;
    end
  end

  always_comb begin
    row_rst = '0;
    for (int j = 0; j < WAYS; j++) begin
      row_rst[j*WF+P_RNK +: WAY_W] = WAY_W'(WAYS - 1 - j);
    end
  end

  sacc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NSETS)
  ) u_row_ram (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(set_q),
    .wdata(row_wr),
    .re   (cmd.capture),
    .raddr(set_in),
    .rdata(ram_rdata)
  );

  assign row_rd = row_init[set_q] ? ram_rdata : row_rst;

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tag_r[j] = row_rd[j*WF +: TW];
      val_r[j] = row_rd[j*WF+P_VAL];
      drt_r[j] = row_rd[j*WF+P_DRT];
      rnk_r[j] = row_rd[j*WF+P_RNK +: WAY_W];
      cnt_r[j] = row_rd[j*WF+P_CNT +: COUNT_WIDTH];
    end
    age_r = row_rd[WAYS*WF +: COUNT_WIDTH];
  end

  // Way searches; ties go to the lowest-numbered way.
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    lfu_way   = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (val_r[j] && tag_r[j] == tag_q) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(j);
      end
      if (!val_r[j]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(j);
      end
    end
    for (int j = 1; j < WAYS; j++) begin
      if (rnk_r[j] > rnk_r[lru_way]) begin
        lru_way = WAY_W'(j);
      end
      if (cnt_r[j] < cnt_r[lfu_way]) begin
        lfu_way = WAY_W'(j);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tag_w[j] = tag_r[j];
      val_w[j] = val_r[j];
      drt_w[j] = drt_r[j];
      cnt_w[j] = cnt_r[j];
    end
    age_w     = age_r;
    sel_way   = '0;
    do_touch  = 1'b0;
    res_hit   = 1'b0;
    res_alloc = 1'b0;
    res_evict = 1'b0;
    res_eaddr = '0;
    if (hit_found) begin
      sel_way = hit_way;
      res_hit = 1'b1;
      if (cfg.repl_policy == sacc_pkg::POLICY_LFU) begin
        cnt_w[hit_way] = (&cnt_r[hit_way]) ? cnt_r[hit_way]
                                           : cnt_r[hit_way] + 1'b1;
      end else begin
        do_touch = 1'b1;
      end
      if (op_q == sacc_pkg::OP_WRITE && cfg.write_back_mode) begin
        drt_w[hit_way] = 1'b1;
      end
    end else if (!(op_q == sacc_pkg::OP_WRITE && !cfg.write_back_mode)) begin
      res_alloc = 1'b1;
      if (inv_found) begin
        sel_way = inv_way;
        if (cfg.repl_policy == sacc_pkg::POLICY_LFU) begin
          cnt_w[inv_way] = (&age_r) ? age_r : age_r + 1'b1;
        end else begin
          do_touch = 1'b1;
        end
      end else begin
        sel_way = (cfg.repl_policy == sacc_pkg::POLICY_LFU) ? lfu_way : lru_way;
        if (drt_r[sel_way]) begin
          res_evict = 1'b1;
          res_eaddr = (32'(set_q) << cfg.offset_bits) | (tag_r[sel_way] << tag_sh);
        end
        if (cfg.repl_policy == sacc_pkg::POLICY_LFU) begin
          age_w          = cnt_r[sel_way];
          cnt_w[sel_way] = (&cnt_r[sel_way]) ? cnt_r[sel_way]
                                             : cnt_r[sel_way] + 1'b1;
        end else begin
          do_touch = 1'b1;
        end
      end
      tag_w[sel_way] = tag_q;
      val_w[sel_way] = 1'b1;
      drt_w[sel_way] = op_q;
    end
  end

  // Rank update: ways younger than the touched way age by one.
  always_comb begin
    touch_rank = rnk_r[sel_way];
    for (int j = 0; j < WAYS; j++) begin
      rnk_w[j] = rnk_r[j];
      if (do_touch) begin
        if (WAY_W'(j) == sel_way) begin
          rnk_w[j] = '0;
        end else if (rnk_r[j] < touch_rank) begin
          rnk_w[j] = rnk_r[j] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      row_wr[j*WF +: TW]                  = tag_w[j];
      row_wr[j*WF+P_VAL]                  = val_w[j];
      row_wr[j*WF+P_DRT]                  = drt_w[j];
      row_wr[j*WF+P_RNK +: WAY_W]         = rnk_w[j];
      row_wr[j*WF+P_CNT +: COUNT_WIDTH]   = cnt_w[j];
    end
    row_wr[WAYS*WF +: COUNT_WIDTH] = age_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {3'b000, res_eaddr, res_evict, res_alloc,
                  ((res_hit || res_alloc) ? sacc_pkg::WAY_OUT_W'(sel_way) : 2'b00),
                  res_hit};
    end
  end

  assign stat.out_busy = m_tvalid && !m_tready;

endmodule

>>> rtl/set_assoc_cache_lru_lfu_controller_top.sv
// Set-associative cache tag controller: each transfer on the s_ side is one
// read or write address; the m_ side returns hit, way, allocation and dirty
// eviction for it. Each access reads the set's row (tags, valid, dirty, LRU
// ranks, LFU counts and set age) from a RAM with one read and one write port,
// then writes it back updated once the result register has room; no new access
// is accepted before that. Rows never written read as their reset contents
// through one valid flop per set, so no clearing pass is needed after reset.
// The user writes configuration through the APB port while idle; not enforced.
module set_assoc_cache_lru_lfu_controller_top #(
  parameter int WAYS        = sacc_pkg::WAYS_DEF,
  parameter int SETS_LOG2   = sacc_pkg::SETS_LOG2_DEF,
  parameter int COUNT_WIDTH = sacc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // addr[31:0]
  input  logic [0:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // hit, way[1:0], allocated, evict_dirty, evict_addr[31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sacc_pkg::cfg_t  cfg;
  sacc_pkg::cmd_t  cmd;
  sacc_pkg::stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repl_policy     <= sacc_pkg::RST_REPL_POLICY;
      cfg.write_back_mode <= sacc_pkg::RST_WB_MODE;
      cfg.offset_bits     <= sacc_pkg::RST_OFFSET_BITS;
      cfg.index_bits      <= sacc_pkg::RST_INDEX_BITS;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        sacc_pkg::REG_REPL_POLICY: cfg.repl_policy     <= pwdata[0];
        sacc_pkg::REG_WB_MODE:     cfg.write_back_mode <= pwdata[0];
        sacc_pkg::REG_OFFSET_BITS: cfg.offset_bits     <= pwdata[3:0];
        sacc_pkg::REG_INDEX_BITS:  cfg.index_bits      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      sacc_pkg::REG_REPL_POLICY: prdata = {31'd0, cfg.repl_policy};
      sacc_pkg::REG_WB_MODE:     prdata = {31'd0, cfg.write_back_mode};
      sacc_pkg::REG_OFFSET_BITS: prdata = {28'd0, cfg.offset_bits};
      sacc_pkg::REG_INDEX_BITS:  prdata = {28'd0, cfg.index_bits};
      default:                   prdata = '0;
    endcase
  end

  sacc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sacc_dp #(
    .WAYS       (WAYS),
    .SETS_LOG2  (SETS_LOG2),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser[0]),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second access accepted during lookup");

  a_hit_not_alloc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[3]))
    else $error("result reports both hit and allocation");

  a_evict_needs_alloc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> m_tdata[3])
    else $error("dirty eviction without allocation");
`endif

endmodule
